>>> rtl/filament_jam_detector_core_assert.svh
// ----------------------------------------------------------------------------
// filament jam detector assertion macros
// clocked assertion helpers, one with and one without the reset guard
// ----------------------------------------------------------------------------
`ifndef FILAMENT_JAM_DETECTOR_CORE_ASSERT_SVH
`define FILAMENT_JAM_DETECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define FJD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every clock edge, reset included
`define FJD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FJD_ASSERT(label, prop, msg)
`define FJD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/fjd_pkg.sv
// ----------------------------------------------------------------------------
// fjd_pkg
// shared types and constants of the filament jam detector
// ----------------------------------------------------------------------------
package fjd_pkg;

  localparam int unsigned POS_W   = 31;
  localparam int unsigned MOVED_W = 32;
  localparam int unsigned PPM_W   = 16;
  localparam int unsigned PROD_W  = POS_W + PPM_W;
  localparam int unsigned CFG_W   = 16;

  // event codes
  typedef enum logic [2:0] {
    MODE_PULSE   = 3'd0,
    MODE_TICK    = 3'd1,
    MODE_BULGE   = 3'd2,
    MODE_DISABLE = 3'd3,
    MODE_ENABLE  = 3'd4,
    MODE_RESUME  = 3'd5,
    MODE_STATUS  = 3'd6
  } mode_t;

  // register indexes
  localparam logic [1:0] CFG_CHECK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_PULSE_SCALE  = 2'd1;
  localparam logic [1:0] CFG_BULGE_ENABLE = 2'd2;

  localparam logic [7:0]       CHECK_PERIOD_RST = 8'd2;
  localparam logic [PPM_W-1:0] PULSE_SCALE_RST  = 16'd256;

  // alarm codes
  localparam logic [1:0] ALARM_NONE  = 2'd0;
  localparam logic [1:0] ALARM_JAM   = 2'd1;
  localparam logic [1:0] ALARM_BULGE = 2'd2;

  typedef struct packed {
    logic             en;
    logic [1:0]       index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              bulge_level;
    logic [POS_W-1:0]  position;
    logic [2:0]        mode;
  } item_t;

  typedef struct packed {
    logic [MOVED_W-1:0] moved_since_check;
    logic [15:0]        pulses_seen;
    logic               is_enabled;
    logic               is_suspended;
    logic               suspend_request;
    logic [1:0]         alarm_kind;
  } result_t;

endpackage

>>> rtl/fjd_step.sv
// ----------------------------------------------------------------------------
// fjd_step
// detector state, config registers and the per-event update logic
// ----------------------------------------------------------------------------
module fjd_step
  import fjd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [7:0]       check_period;
  logic [PPM_W-1:0] ppm_scale;
  logic             bulge_enable;

  logic [15:0]      pulse_counter, pulse_counter_next;
  logic [7:0]       seconds_elapsed, seconds_elapsed_next;
  logic [POS_W-1:0] last_position, last_position_next;
  logic             last_valid, last_valid_next;
  logic             enabled_flag, enabled_flag_next;
  logic             suspended_flag, suspended_flag_next;
  logic             alarm_pending, alarm_pending_next;
  logic             bulge_seen, bulge_seen_next;

  logic signed [MOVED_W-1:0] diff;
  logic [PROD_W-1:0]         product;
  logic                      needed_nz;
  logic [7:0]                seconds_inc;

  // shared position difference, used by the check and by status
  assign diff = $signed({item.position[POS_W-1], item.position})
              - $signed({last_position[POS_W-1], last_position});
  assign product = {{PPM_W{1'b0}}, diff[POS_W-1:0]} * {{POS_W{1'b0}}, ppm_scale};
  assign needed_nz = |product[PROD_W-1:16];
  assign seconds_inc = (seconds_elapsed == 8'hFF) ? seconds_elapsed : seconds_elapsed + 8'd1;

  always_comb begin
    pulse_counter_next   = pulse_counter;
    seconds_elapsed_next = seconds_elapsed;
    last_position_next   = last_position;
    last_valid_next      = last_valid;
    enabled_flag_next    = enabled_flag;
    suspended_flag_next  = suspended_flag;
    alarm_pending_next   = alarm_pending;
    bulge_seen_next      = bulge_seen;
    result               = '0;

    unique case (item.mode)
      MODE_PULSE: begin
        if (pulse_counter != 16'hFFFF) pulse_counter_next = pulse_counter + 16'd1;
      end
      MODE_TICK: begin
        if (seconds_inc >= check_period) begin
          seconds_elapsed_next = '0;
          if (!suspended_flag && enabled_flag) begin
            pulse_counter_next = '0;
            last_position_next = item.position;
            last_valid_next    = 1'b1;
            if (last_valid && !diff[MOVED_W-1] && needed_nz && pulse_counter == '0)
              alarm_pending_next = 1'b1;
          end
        end else begin
          seconds_elapsed_next = seconds_inc;
        end
      end
      MODE_BULGE: begin
        if (bulge_enable && !suspended_flag && item.bulge_level) begin
          alarm_pending_next = 1'b1;
          bulge_seen_next    = 1'b1;
        end
      end
      MODE_DISABLE: begin
        enabled_flag_next  = 1'b0;
        last_position_next = item.position;
        last_valid_next    = 1'b1;
      end
      MODE_ENABLE: begin
        pulse_counter_next = '0;
        last_position_next = item.position;
        last_valid_next    = 1'b1;
        enabled_flag_next  = 1'b1;
      end
      MODE_RESUME: begin
        if (suspended_flag) begin
          pulse_counter_next  = '0;
          last_valid_next     = 1'b0;
          suspended_flag_next = 1'b0;
        end
      end
      MODE_STATUS: begin
        if (last_valid) result.moved_since_check = diff;
      end
      default: begin
      end
    endcase

    // report a pending alarm once enabled
    if (enabled_flag_next && alarm_pending_next) begin
      alarm_pending_next = 1'b0;
      if (bulge_seen_next) begin
        result.alarm_kind = ALARM_BULGE;
        bulge_seen_next   = 1'b0;
      end else begin
        result.alarm_kind = ALARM_JAM;
      end
      if (!suspended_flag_next) begin
        suspended_flag_next    = 1'b1;
        result.suspend_request = 1'b1;
      end
    end

    result.is_suspended = suspended_flag_next;
    result.is_enabled   = enabled_flag_next;
    result.pulses_seen  = pulse_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_period    <= CHECK_PERIOD_RST;
      ppm_scale       <= PULSE_SCALE_RST;
      bulge_enable    <= 1'b0;
      pulse_counter   <= '0;
      seconds_elapsed <= '0;
      last_position   <= '0;
      last_valid      <= 1'b0;
      enabled_flag    <= 1'b1;
      suspended_flag  <= 1'b0;
      alarm_pending   <= 1'b0;
      bulge_seen      <= 1'b0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        CFG_CHECK_PERIOD: begin
          check_period    <= cfg.data[7:0];
          seconds_elapsed <= '0;
        end
        CFG_PULSE_SCALE:  ppm_scale <= cfg.data;
        CFG_BULGE_ENABLE: bulge_enable <= cfg.data[0];
        default: begin
        end
      endcase
    end else if (fire) begin
      pulse_counter   <= pulse_counter_next;
      seconds_elapsed <= seconds_elapsed_next;
      last_position   <= last_position_next;
      last_valid      <= last_valid_next;
      enabled_flag    <= enabled_flag_next;
      suspended_flag  <= suspended_flag_next;
      alarm_pending   <= alarm_pending_next;
      bulge_seen      <= bulge_seen_next;
    end
  end

endmodule

>>> rtl/filament_jam_detector_core.sv
// ----------------------------------------------------------------------------
// filament_jam_detector_core
// filament jam and bulge detector with stream event input and status output
// ----------------------------------------------------------------------------
// Every event request yields exactly one status request. The core takes one
// event per clock: an event lands in the input register, is evaluated by a
// single pass through the step logic (one 31x16 multiply and a compare
// against the needed-pulse threshold) once it can advance, and is written to
// the output register, so throughput is one event per cycle as long as the
// output side takes its requests. When the output register is full and
// m_tready is low the input register holds and s_tready drops.
// Configuration writes are taken at any edge with cfg_wr_en high and must
// only be issued while no event is in flight; writing the check period also
// restarts the seconds count. Positions are signed 1/256 mm, the pulse scale
// (pulses per mm) is unsigned Q8.8, and a check raises a jam when a forward
// move needs at least one pulse while none was counted.
module filament_jam_detector_core
  import fjd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // position[30:0], bulge_level[31]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  // status stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // alarm_kind[1:0], suspend_request[2], is_suspended[3],
                                 // is_enabled[4], pulses_seen[20:5],
                                 // moved_since_check[52:21], zero pad[55:53]
);

  `include "filament_jam_detector_core_assert.svh"

  // input register
  logic    in_valid;
  item_t   in_item;
  // output register
  logic    out_valid;
  result_t out_result;

  logic    advance;
  cfg_wr_t cfg;
  result_t step_result;

  // the held event moves on when the output slot is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode        <= s_tuser;
      in_item.position    <= s_tdata[POS_W-1:0];
      in_item.bulge_level <= s_tdata[POS_W];
    end
  end

  // state, config and per-event logic
  fjd_step u_step (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (in_item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_result};

  // a suspend request always comes with an alarm and a suspended flag
  `FJD_ASSERT(a_req_has_alarm, out_valid && out_result.suspend_request |-> out_result.is_suspended && out_result.alarm_kind != ALARM_NONE, "suspend request without alarm")
  // alarm code 3 is never produced
  `FJD_ASSERT(a_alarm_code, out_valid |-> out_result.alarm_kind != 2'd3, "bad alarm code")
  // back-pressure only ever comes from a held event
  `FJD_ASSERT_ALWAYS(a_stall_src, !s_tready |-> in_valid && out_valid && !m_tready, "stall without a full pipeline")
  // an evaluated event is always presented next cycle
  `FJD_ASSERT(a_adv_out, advance |=> m_tvalid, "evaluated event lost")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the filament jam detector core: events are sent on
// the slave stream under random idling and back-pressure, every status
// request is compared with an in-bench model of the counters and flags
// ----------------------------------------------------------------------------
module tb_top;
  import fjd_pkg::*;

  // codes the package does not name
  localparam logic [2:0] MODE_NOP  = 3'd7;   // unused event code, flags only
  localparam logic [1:0] CFG_SPARE = 2'd3;   // register index with no register

  localparam logic [30:0] POS_MAX = 31'h3FFF_FFFF;
  localparam logic [30:0] POS_MIN = 31'h4000_0000;

  localparam int SINK_HOLD_CYCLES = 200;   // long output stall for the fill test
  localparam int QUIET_LIMIT      = 2000;  // cycles with no handshake and no register write
  localparam int DRAIN_CYCLES     = 4;     // two-stage core, plus margin

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // position[30:0], bulge_level[31]
  logic [2:0]  s_tuser = '0;   // mode[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // alarm_kind[1:0], suspend_request[2], is_suspended[3],
                               // is_enabled[4], pulses_seen[20:5], moved_since_check[52:21]

  filament_jam_detector_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // detector model: registers and state, starting at their reset values
  // --------------------------------------------------------------------------
  logic [7:0]  period_reg  = CHECK_PERIOD_RST;
  logic [15:0] ppm_reg     = PULSE_SCALE_RST;
  logic        bulge_en_reg = 1'b0;

  logic [15:0] model_pulses = '0;
  logic [7:0]  secs_cnt    = '0;
  logic [30:0] last_pos    = '0;
  logic        last_ok     = 1'b0;
  logic        enabled     = 1'b1;
  logic        suspended   = 1'b0;
  logic        alarm_armed = 1'b0;
  logic        bulge_flag  = 1'b0;

  result_t pending_status[$];   // predicted status requests, oldest first

  // bench control and tallies
  bit src_idle_on   = 1'b0;
  bit sink_idle_on  = 1'b0;
  bit sink_hold_req = 1'b0;
  int walk_pos      = 0;
  int pulse_pct     = 20;
  int mismatch_count = 0;
  int events_sent   = 0;
  int status_checked = 0;
  int jam_count     = 0;
  int bulge_count   = 0;
  int setting_count = 0;

  // one event through the model, returns the status it must produce
  function automatic result_t predict_status(logic [2:0] mode, logic [30:0] pos,
                                             logic level);
    result_t     r;
    logic [31:0] delta;
    logic [47:0] prod;
    logic [15:0] seen;
    r = '0;
    case (mode)
      MODE_PULSE: begin
        if (model_pulses != 16'hFFFF) model_pulses++;
      end
      MODE_TICK: begin
        if (secs_cnt != 8'hFF) secs_cnt++;
        if (secs_cnt >= period_reg) begin
          secs_cnt = '0;
          // no check at all while suspended or disabled
          if (!suspended && enabled) begin
            seen = model_pulses;
            model_pulses = '0;
            if (!last_ok) begin
              last_pos = pos;
              last_ok = 1'b1;
            end else begin
              delta = {pos[30], pos} - {last_pos[30], last_pos};
              last_pos = pos;
              // retracts never raise a jam
              if (!delta[31]) begin
                prod = {17'b0, delta[30:0]} * {32'b0, ppm_reg};
                if (prod[47:16] != 0 && seen == 0) alarm_armed = 1'b1;
              end
            end
          end
        end
      end
      MODE_BULGE: begin
        if (bulge_en_reg && !suspended && level) begin
          alarm_armed = 1'b1;
          bulge_flag = 1'b1;
        end
      end
      MODE_DISABLE: begin
        enabled = 1'b0;
        last_pos = pos;
        last_ok = 1'b1;
      end
      MODE_ENABLE: begin
        model_pulses = '0;
        last_pos = pos;
        last_ok = 1'b1;
        enabled = 1'b1;
      end
      MODE_RESUME: begin
        if (suspended) begin
          model_pulses = '0;
          last_ok = 1'b0;
          suspended = 1'b0;
        end
      end
      MODE_STATUS: begin
        if (last_ok) r.moved_since_check = {pos[30], pos} - {last_pos[30], last_pos};
      end
      default: ;
    endcase
    // a pending alarm surfaces only once the block is enabled
    if (enabled && alarm_armed) begin
      alarm_armed = 1'b0;
      if (bulge_flag) begin
        r.alarm_kind = ALARM_BULGE;
        bulge_flag = 1'b0;
      end else begin
        r.alarm_kind = ALARM_JAM;
      end
      if (!suspended) begin
        suspended = 1'b1;
        r.suspend_request = 1'b1;
      end
    end
    r.is_suspended = suspended;
    r.is_enabled = enabled;
    r.pulses_seen = model_pulses;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // event sender: one request, with an optional idle burst in front
  // --------------------------------------------------------------------------
  task automatic send_event(input logic [2:0] mode, input logic [30:0] pos,
                            input logic level);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {level, pos};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    pending_status.push_back(predict_status(mode, pos, level));
    events_sent++;
  endtask

  // stop offering, wait for every status to come back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued with the core empty
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_CHECK_PERIOD: begin
        period_reg = value[7:0];
        secs_cnt = '0;   // a new period restarts the seconds count
      end
      CFG_PULSE_SCALE:  ppm_reg = value;
      CFG_BULGE_ENABLE: bulge_en_reg = value[0];
      default: ;
    endcase
  endtask

  // all three registers one after the other, junk in the unused upper bits
  task automatic apply_setting(input logic [7:0] period, input logic [15:0] ppm,
                               input logic bulge_en);
    write_reg(CFG_CHECK_PERIOD, {8'($urandom()), period});
    write_reg(CFG_PULSE_SCALE, ppm);
    write_reg(CFG_BULGE_ENABLE, {15'($urandom()), bulge_en});
    setting_count++;
  endtask

  // mostly a printing extruder walking forward, with some noise events
  task automatic random_event();
    int         pick;
    logic [2:0] m;
    logic [30:0] p;
    logic       lvl;
    pick = $urandom_range(0, 99);
    lvl = ($urandom_range(0, 3) == 0);
    if (pick < 4) begin
      m = 3'($urandom_range(0, 7));
      p = 31'($urandom());
      lvl = 1'($urandom());
    end else begin
      if ($urandom_range(0, 9) == 0) walk_pos = walk_pos - int'($urandom_range(0, 2000));
      else walk_pos = walk_pos + int'($urandom_range(0, 1500));
      if (walk_pos > (1 << 29) || walk_pos < -(1 << 29)) walk_pos = 0;
      p = 31'(walk_pos);
      if (pick < 4 + pulse_pct) m = MODE_PULSE;
      else if (pick < 60) m = MODE_TICK;
      else if (pick < 68) m = MODE_BULGE;
      else if (pick < 78) m = MODE_STATUS;
      else if (pick < 90) begin
        // resume mostly when it matters
        if (suspended || $urandom_range(0, 2) == 0) m = MODE_RESUME;
        else m = MODE_TICK;
      end
      else if (pick < 94) m = MODE_DISABLE;
      else if (pick < 99) m = MODE_ENABLE;
      else m = MODE_NOP;
    end
    send_event(m, p, lvl);
  endtask

  // --------------------------------------------------------------------------
  // output side: ready pattern with idle bursts and the long hold
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // status checker, oldest prediction first
  always @(posedge clk) begin : status_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[52:0]);
      if (pending_status.size() == 0) begin
        $error("status request with nothing expected: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("alarm_kind", want.alarm_kind, got.alarm_kind);
        check_field("suspend_request", want.suspend_request, got.suspend_request);
        check_field("is_suspended", want.is_suspended, got.is_suspended);
        check_field("is_enabled", want.is_enabled, got.is_enabled);
        check_field("pulses_seen", want.pulses_seen, got.pulses_seen);
        check_field("moved_since_check", $signed(want.moved_since_check),
                    $signed(got.moved_since_check));
        status_checked++;
        if (want.alarm_kind == ALARM_JAM) jam_count++;
        if (want.alarm_kind == ALARM_BULGE) bulge_count++;
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d statuses outstanding",
               quiet_cycles, pending_status.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every event code and the corner cases, reset settings first
  task automatic test_directed_events();
    send_event(MODE_STATUS, 31'd100, 1'b0);     // no stored position, moved is zero
    send_event(MODE_RESUME, 31'd0, 1'b0);       // resume while running is ignored
    send_event(MODE_BULGE, 31'd0, 1'b1);        // bulge sensor off, ignored
    send_event(MODE_NOP, POS_MAX, 1'b1);        // unused code only reports flags
    send_event(MODE_TICK, 31'd0, 1'b0);
    send_event(MODE_TICK, 31'd0, 1'b0);         // first check just stores the position
    send_event(MODE_TICK, 31'd1000, 1'b0);
    send_event(MODE_TICK, 31'd5000, 1'b0);      // forward move, no pulses: jam
    send_event(MODE_TICK, 31'd9000, 1'b0);
    send_event(MODE_TICK, 31'd9000, 1'b0);      // check skipped while suspended
    send_event(MODE_RESUME, 31'd0, 1'b0);
    send_event(MODE_STATUS, POS_MAX, 1'b0);
    send_event(MODE_DISABLE, POS_MIN, 1'b0);
    send_event(MODE_STATUS, POS_MAX, 1'b0);     // largest positive move
    send_event(MODE_PULSE, 31'd0, 1'b0);
    send_event(MODE_ENABLE, POS_MAX, 1'b0);
    send_event(MODE_STATUS, POS_MIN, 1'b0);     // largest negative move
    // bulge sensor on, check on every tick, steepest scale
    apply_setting(8'd0, 16'hFFFF, 1'b1);
    send_event(MODE_BULGE, 31'd0, 1'b1);        // bulge alarm
    send_event(MODE_BULGE, 31'd0, 1'b1);        // ignored while suspended
    send_event(MODE_RESUME, 31'd0, 1'b0);
    send_event(MODE_DISABLE, 31'd0, 1'b0);
    send_event(MODE_BULGE, 31'd0, 1'b1);        // held back while disabled
    send_event(MODE_PULSE, 31'd0, 1'b0);
    send_event(MODE_ENABLE, 31'd0, 1'b0);       // alarm surfaces here
    send_event(MODE_RESUME, 31'd0, 1'b0);
    send_event(MODE_TICK, POS_MIN, 1'b0);       // stores after resume
    send_event(MODE_TICK, POS_MAX, 1'b0);       // widest product
    send_event(MODE_RESUME, 31'd0, 1'b0);
    write_reg(CFG_SPARE, 16'hFFFF);             // no register behind this index
    send_event(MODE_STATUS, 31'd7, 1'b0);
  endtask

  // a run of pulses back to back, then enable clears the count
  task automatic test_pulse_run();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (60) send_event(MODE_PULSE, 31'($urandom()), 1'($urandom()));
    send_event(MODE_ENABLE, 31'd0, 1'b0);
    drain();
  endtask

  // output held off long enough for the core to fill and stall its input
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    sink_hold_req = 1'b1;
    repeat (40) random_event();
    drain();
  endtask

  // one random phase under a given setting
  task automatic test_random_phase(input logic [7:0] period, input logic [15:0] ppm,
                                   input logic bulge_en, input int n_items);
    apply_setting(period, ppm, bulge_en);
    pulse_pct = $urandom_range(0, 40);
    repeat (n_items) random_event();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_events();
    test_pulse_run();
    test_output_backpressure();

    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    test_random_phase(8'd2, 16'd256, 1'b0, 140);
    test_random_phase(8'd0, 16'd256, 1'b1, 140);
    test_random_phase(8'd1, 16'hFFFF, 1'b1, 140);
    test_random_phase(8'd3, 16'd1, 1'b0, 140);
    test_random_phase(8'd255, 16'($urandom()), 1'b1, 140);
    test_random_phase(8'd0, 16'd0, 1'b1, 140);
    test_random_phase(8'd1, 16'($urandom()), 1'($urandom()), 140);
    test_random_phase(8'($urandom_range(0, 4)), 16'($urandom()), 1'b1, 140);

    // closing stretch at full rate on both sides
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random_phase(8'd1, 16'd256, 1'b1, 100);

    drain();
    $display("run covered %0d events under %0d register settings, %0d statuses checked",
             events_sent, setting_count, status_checked);
    $display("alarms observed: %0d jam, %0d bulge", jam_count, bulge_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
